/* design/lpm_pkg.sv */
package lpm_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 3;
  localparam int TTL_W  = 8;
  localparam int STAT_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

  localparam logic [STAT_W-1:0] ST_FORWARDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_TTL_EXPIRED = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_ADDED       = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL        = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  length;
    logic              has_gateway;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic capture;
    logic do_add;
    logic set_expired;
    logic scan_start;
    logic scan_step;
    logic fwd_finish;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic ttl_dead;
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

  // Network mask for a prefix length; the length is already limited to 32.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

/* design/lpm_ram.sv */
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/lpm_ctrl.sv */
module lpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_stall,
  input  lpm_pkg::ctl_sts_t   sts,
  output lpm_pkg::ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_FWD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = in_func ? S_FWD : S_ADD;
        end
      end
      S_ADD: begin
        cmd.do_add = 1'b1;
        state_nxt  = S_PUSH;
      end
      S_FWD: begin
        if (sts.ttl_dead) begin
          cmd.set_expired = 1'b1;
          state_nxt       = S_PUSH;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.fwd_finish = 1'b1;
          state_nxt      = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/lpm_dpath.sv */
module lpm_dpath #(
  parameter int ROUTE_SLOTS = 32,
  parameter int PORT_COUNT  = 8,
  localparam int AW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1,
  localparam int CW = $clog2(ROUTE_SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpm_pkg::ctl_cmd_t            cmd,
  output lpm_pkg::ctl_sts_t            sts,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_new_prefix,
  input  logic [lpm_pkg::LEN_W-1:0]    in_new_prefix_len,
  input  logic                         in_new_has_gateway,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_new_gateway,
  input  logic [lpm_pkg::PORT_W-1:0]   in_new_port,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_dst_addr,
  input  logic [lpm_pkg::TTL_W-1:0]    in_packet_ttl,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [lpm_pkg::STAT_W-1:0]   out_status,
  output logic [lpm_pkg::PORT_W-1:0]   out_out_port,
  output logic [lpm_pkg::ADDR_W-1:0]   out_hop_addr,
  output logic [lpm_pkg::TTL_W-1:0]    out_out_ttl
);

  localparam int RW = $bits(lpm_pkg::route_t);
  localparam logic [CW-1:0] SLOTS = CW'(ROUTE_SLOTS);

  // Captured item.
  logic [lpm_pkg::ADDR_W-1:0] new_prefix_r;
  logic [lpm_pkg::LEN_W-1:0]  new_len_r;
  logic                       new_has_gw_r;
  logic [lpm_pkg::ADDR_W-1:0] new_gw_r;
  logic [lpm_pkg::PORT_W-1:0] new_port_r;
  logic [lpm_pkg::ADDR_W-1:0] dst_r;
  logic [lpm_pkg::TTL_W-1:0]  ttl_r;

  // Table fill and scan state.
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          found_r, found_nxt;
  logic [lpm_pkg::LEN_W-1:0]  best_len_r;
  logic [lpm_pkg::PORT_W-1:0] best_port_r;
  logic [lpm_pkg::ADDR_W-1:0] best_hop_r;

  // Staged result and output register.
  logic [lpm_pkg::STAT_W-1:0] res_status_r;
  logic [lpm_pkg::PORT_W-1:0] res_port_r;
  logic [lpm_pkg::ADDR_W-1:0] res_hop_r;
  logic [lpm_pkg::TTL_W-1:0]  res_ttl_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [lpm_pkg::STAT_W-1:0] out_status_r;
  logic [lpm_pkg::PORT_W-1:0] out_port_r;
  logic [lpm_pkg::ADDR_W-1:0] out_hop_r;
  logic [lpm_pkg::TTL_W-1:0]  out_ttl_r;

  logic              table_full;
  logic              ram_we;
  logic              ram_re;
  lpm_pkg::route_t   wr_route;
  lpm_pkg::route_t   rd_route;
  logic [RW-1:0]     rd_data;
  logic [lpm_pkg::LEN_W-1:0]  sat_len;
  logic [lpm_pkg::PORT_W-1:0] sat_port;
  logic [lpm_pkg::ADDR_W-1:0] rd_mask;
  logic              hit;
  logic              take;

  assign table_full = (count_r >= SLOTS);

  always_comb begin
    sat_len = (new_len_r > lpm_pkg::MAX_LEN) ? lpm_pkg::MAX_LEN : new_len_r;
    if (int'(new_port_r) >= PORT_COUNT) begin
      sat_port = lpm_pkg::PORT_W'(PORT_COUNT - 1);
    end else begin
      sat_port = new_port_r;
    end
    wr_route.prefix      = new_prefix_r;
    wr_route.length      = sat_len;
    wr_route.has_gateway = new_has_gw_r;
    wr_route.gateway     = new_gw_r;
    wr_route.port        = sat_port;
  end

  assign ram_we = cmd.do_add && !table_full;
  assign ram_re = cmd.scan_step && (idx_r < count_r);

  lpm_ram #(
    .WIDTH (RW),
    .DEPTH (ROUTE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_route),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign rd_route = rd_data;
  assign rd_mask  = lpm_pkg::len_mask(rd_route.length);
  assign hit      = ((dst_r & rd_mask) == (rd_route.prefix & rd_mask));
  // Only a strictly longer prefix displaces the current best, so the
  // earliest route wins among equal lengths.
  assign take     = cmd.scan_step && cmp_vld_r && hit &&
                    (!found_r || (best_len_r < rd_route.length));

  always_comb begin
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    cmp_vld_nxt = cmp_vld_r;
    found_nxt   = found_r;
    if (ram_we) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.scan_start) begin
      idx_nxt     = '0;
      cmp_vld_nxt = 1'b0;
      found_nxt   = 1'b0;
    end else if (cmd.scan_step) begin
      cmp_vld_nxt = ram_re;
      if (ram_re) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (take) begin
        found_nxt = 1'b1;
      end
    end
  end

  assign sts.ttl_dead  = (ttl_r <= lpm_pkg::TTL_W'(1));
  assign sts.scan_done = (idx_r == count_r) && !cmp_vld_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_prefix_r <= in_new_prefix;
      new_len_r    <= in_new_prefix_len;
      new_has_gw_r <= in_new_has_gateway;
      new_gw_r     <= in_new_gateway;
      new_port_r   <= in_new_port;
      dst_r        <= in_dst_addr;
      ttl_r        <= in_packet_ttl;
    end
    if (take) begin
      best_len_r  <= rd_route.length;
      best_port_r <= rd_route.port;
      best_hop_r  <= rd_route.has_gateway ? rd_route.gateway : dst_r;
    end
    if (cmd.do_add) begin
      res_status_r <= table_full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
      res_port_r   <= '0;
      res_hop_r    <= '0;
      res_ttl_r    <= '0;
    end else if (cmd.set_expired) begin
      res_status_r <= lpm_pkg::ST_TTL_EXPIRED;
      res_port_r   <= '0;
      res_hop_r    <= '0;
      res_ttl_r    <= '0;
    end else if (cmd.fwd_finish) begin
      if (found_r) begin
        res_status_r <= lpm_pkg::ST_FORWARDED;
        res_port_r   <= best_port_r;
        res_hop_r    <= best_hop_r;
        res_ttl_r    <= ttl_r - lpm_pkg::TTL_W'(1);
      end else begin
        res_status_r <= lpm_pkg::ST_NO_ROUTE;
        res_port_r   <= '0;
        res_hop_r    <= '0;
        res_ttl_r    <= '0;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_port_r   <= res_port_r;
      out_hop_r    <= res_hop_r;
      out_ttl_r    <= res_ttl_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_out_port = out_port_r;
  assign out_hop_addr = out_hop_r;
  assign out_out_ttl  = out_ttl_r;

endmodule

/* design/ipv4_longest_prefix_router.sv */
// IPv4 longest-prefix router. Each item either adds a route (func 0) or
// forwards one header (func 1), and produces exactly one result item. Routes
// live in a single-port-read table of ROUTE_SLOTS entries, walked one entry
// per cycle. A finished result waits to load while the previous result still
// sits stalled in the output register. Items are taken one at a time, and a
// new item can enter while the previous result waits on out_stall.
module ipv4_longest_prefix_router #(
  parameter int ROUTE_SLOTS = 32,
  parameter int PORT_COUNT  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_new_prefix,
  input  logic [lpm_pkg::LEN_W-1:0]    in_new_prefix_len,
  input  logic                         in_new_has_gateway,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_new_gateway,
  input  logic [lpm_pkg::PORT_W-1:0]   in_new_port,
  input  logic [lpm_pkg::ADDR_W-1:0]   in_dst_addr,
  input  logic [lpm_pkg::TTL_W-1:0]    in_packet_ttl,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lpm_pkg::STAT_W-1:0]   out_status,
  output logic [lpm_pkg::PORT_W-1:0]   out_out_port,
  output logic [lpm_pkg::ADDR_W-1:0]   out_hop_addr,
  output logic [lpm_pkg::TTL_W-1:0]    out_out_ttl
);

  lpm_pkg::ctl_cmd_t cmd;
  lpm_pkg::ctl_sts_t sts;

  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpm_dpath #(
    .ROUTE_SLOTS (ROUTE_SLOTS),
    .PORT_COUNT  (PORT_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_new_prefix      (in_new_prefix),
    .in_new_prefix_len  (in_new_prefix_len),
    .in_new_has_gateway (in_new_has_gateway),
    .in_new_gateway     (in_new_gateway),
    .in_new_port        (in_new_port),
    .in_dst_addr        (in_dst_addr),
    .in_packet_ttl      (in_packet_ttl),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_out_port       (out_out_port),
    .out_hop_addr       (out_hop_addr),
    .out_out_ttl        (out_out_ttl)
  );

endmodule
